@@ hdl/wvde_pkg.sv @@
// ----------------------------------------------------------------------------
// wvde_pkg
// Shared types and constants of the wind vane direction estimator: request,
// response and queue item layouts, configuration layout, register indexes.
// ----------------------------------------------------------------------------
package wvde_pkg;

   // Fixed field widths
   localparam int RES_W     = 20;
   localparam int CODE_W    = 12;
   localparam int CNT_W     = 11;
   localparam int STEP_W    = 12;
   localparam int DIR_W     = 4;
   localparam int TENTHS_W  = 16;
   localparam int ENTRY_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   // Request kinds
   localparam logic REQ_TABLE_WRITE = 1'b0;
   localparam logic REQ_SAMPLE      = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES_RES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_CNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_STEP   = 2'd2;

   typedef struct packed {
      logic                req_type;
      logic [ENTRY_W-1:0]  entry_index;
      logic [RES_W-1:0]    entry_resistance;
      logic [CODE_W-1:0]   sample_code;
   } wvde_req_type;

   typedef struct packed {
      logic [DIR_W-1:0]    direction_index;
      logic [TENTHS_W-1:0] direction_tenths;
   } wvde_rsp_type;

   // Classified work for the back end
   typedef enum logic [1:0] {
      OP_WRITE,
      OP_SAMPLE,
      OP_FULL_SCALE
   } wvde_op_type;

   typedef struct packed {
      wvde_op_type         op;
      logic [ENTRY_W-1:0]  index;
      logic [RES_W-1:0]    resistance;
      logic [CODE_W-1:0]   code;
   } wvde_item_type;

   // Live configuration seen by the back end
   typedef struct packed {
      logic [RES_W-1:0]    series_resistance;
      logic [CNT_W-1:0]    window_limit;
      logic [STEP_W-1:0]   direction_step;
   } wvde_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } wvde_state_type;

endpackage

@@ hdl/wvde_front.sv @@
// ----------------------------------------------------------------------------
// wvde_front
// Request front end: accepts request beats, classifies them into table
// writes, regular samples and full-scale samples, drops writes beyond the
// table, and pushes the rest into the work queue.
// ----------------------------------------------------------------------------
module wvde_front #(
   parameter int NUM_DIRECTIONS = 16,
   parameter int ADC_FULL_SCALE = 4095
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  wvde_pkg::wvde_req_type req_data,
   output logic                   push_valid,
   input  logic                   push_ready,
   output wvde_pkg::wvde_item_type push_item
);
   import wvde_pkg::*;

   logic entry_in_range;
   logic code_full_scale;

   assign entry_in_range  = int'(req_data.entry_index) < NUM_DIRECTIONS;
   assign code_full_scale = int'(req_data.sample_code) >= ADC_FULL_SCALE;

   // Take a beat whenever the queue has room
   assign req_ready = push_ready;

   // Drop writes that land outside the table
   assign push_valid = req_valid &&
                       ((req_data.req_type == REQ_SAMPLE) || entry_in_range);

   // Classify the beat
   always_comb begin
      push_item.index      = req_data.entry_index;
      push_item.resistance = req_data.entry_resistance;
      push_item.code       = req_data.sample_code;
      priority if (req_data.req_type == REQ_TABLE_WRITE) begin
         push_item.op = OP_WRITE;
      end else if (code_full_scale) begin
         push_item.op = OP_FULL_SCALE;
      end else begin
         push_item.op = OP_SAMPLE;
      end
   end

endmodule

@@ hdl/wvde_queue.sv @@
// ----------------------------------------------------------------------------
// wvde_queue
// Two-entry work queue between front end and back end, so either side can
// stall without holding the other.
// ----------------------------------------------------------------------------
module wvde_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  wvde_pkg::wvde_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output wvde_pkg::wvde_item_type pop_item
);
   import wvde_pkg::*;

   wvde_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/wvde_back.sv @@
// ----------------------------------------------------------------------------
// wvde_back
// Back end sequencer: owns the resistance table, scans it one entry per
// cycle for the nearest match, accumulates indices over the window, runs a
// restoring divider for the rounded average and holds the result in the
// output register.
// ----------------------------------------------------------------------------
module wvde_back #(
   parameter int NUM_DIRECTIONS = 16,
   parameter int ADC_FULL_SCALE = 4095
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   output logic                    item_ready,
   input  wvde_pkg::wvde_item_type item,
   input  wvde_pkg::wvde_cfg_type  cfg,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output wvde_pkg::wvde_rsp_type  rsp_data
);
   import wvde_pkg::*;

   localparam int IDX_W   = $clog2(NUM_DIRECTIONS);
   localparam int FULL_W  = $clog2(ADC_FULL_SCALE + 1);
   localparam int LHS_W   = RES_W + CODE_W;
   localparam int RHS_W   = RES_W + FULL_W;
   localparam int PROD_W  = (RHS_W > LHS_W) ? RHS_W : LHS_W;
   localparam int SCAN_W  = $clog2(NUM_DIRECTIONS + 2);
   localparam int SUM_W   = IDX_W + CNT_W;
   localparam int NUM_W   = SUM_W + 2;
   localparam int STEP_CW = (IDX_W > 1) ? $clog2(IDX_W) : 1;

   localparam logic [FULL_W-1:0]  FULL_V     = FULL_W'(ADC_FULL_SCALE);
   localparam logic [SCAN_W-1:0]  SCAN_LAST  = SCAN_W'(NUM_DIRECTIONS + 1);
   localparam logic [SCAN_W-1:0]  SCAN_FIRST = SCAN_W'(2);
   localparam logic [STEP_CW-1:0] STEP_LAST  = STEP_CW'(IDX_W - 1);

   // Table memory
   logic [RES_W-1:0]  table_mem [NUM_DIRECTIONS];
   logic [RES_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic              mem_we;

   wvde_state_type    state_ff, state_in;

   // Scan datapath
   logic [PROD_W-1:0] lhs_ff;
   logic [FULL_W-1:0] rem_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] best_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [LHS_W-1:0]  lhs_full;
   logic [RHS_W-1:0]  rhs_full;
   logic [PROD_W-1:0] diff;
   logic [IDX_W-1:0]  cmp_idx;
   logic              cmp_valid;
   logic              scan_done;

   // Window accumulation
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_next;
   logic [CNT_W-1:0]  seen_ff, seen_in, seen_next;
   logic              window_close;

   // Divider
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   dsh_ff;
   logic [IDX_W-1:0]   quo_ff;
   logic [STEP_CW-1:0] step_cnt_ff;
   logic               quo_bit;
   logic               div_done;

   // Output stage
   logic               rsp_valid_ff, rsp_valid_in;
   wvde_rsp_type       rsp_data_ff;
   logic               rsp_load;
   logic [DIR_W-1:0]   dir_avg;
   logic [DIR_W+STEP_W-1:0] tenths_full;

   // Products and compare
   assign lhs_full  = cfg.series_resistance * item.code;
   assign rhs_full  = rd_data_ff * rem_ff;
   assign diff      = (lhs_ff >= prod_ff) ? (lhs_ff - prod_ff) : (prod_ff - lhs_ff);
   assign cmp_valid = scan_ff >= SCAN_FIRST;
   assign cmp_idx   = IDX_W'(scan_ff - SCAN_FIRST);
   assign scan_done = scan_ff == SCAN_LAST;

   assign rd_addr = (int'(scan_ff) < NUM_DIRECTIONS) ? scan_ff[IDX_W-1:0] : '0;
   assign wr_addr = IDX_W'(item.index);

   // Close the window on this sample
   assign sum_next     = sum_ff + SUM_W'(best_idx_ff);
   assign seen_next    = seen_ff + CNT_W'(1);
   assign window_close = seen_next >= cfg.window_limit;

   assign quo_bit  = num_ff >= dsh_ff;
   assign div_done = step_cnt_ff == STEP_LAST;

   assign dir_avg     = DIR_W'(quo_ff);
   assign tenths_full = dir_avg * cfg.direction_step;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               unique case (item.op)
                  OP_SAMPLE:     state_in = ST_SCAN;
                  OP_FULL_SCALE: state_in = ST_ACC;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = window_close ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      item_ready = 1'b0;
      mem_we     = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            mem_we     = item_valid && (item.op == OP_WRITE);
         end
         ST_OUT: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            item_ready = 1'b0;
         end
      endcase
   end

   // Window accumulator next values
   always_comb begin
      sum_in  = sum_ff;
      seen_in = seen_ff;
      if (state_ff == ST_ACC) begin
         sum_in  = window_close ? '0 : sum_next;
         seen_in = window_close ? '0 : seen_next;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Table write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[wr_addr] <= item.resistance;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // Scan, divide and output datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            lhs_ff      <= PROD_W'(lhs_full);
            rem_ff      <= FULL_V - FULL_W'(item.code);
            scan_ff     <= '0;
            best_idx_ff <= '0;
         end
         ST_SCAN: begin
            scan_ff <= scan_ff + SCAN_W'(1);
            prod_ff <= PROD_W'(rhs_full);
            // Keep the first entry on a tie
            if (cmp_valid && ((cmp_idx == '0) || (diff < best_ff))) begin
               best_ff     <= diff;
               best_idx_ff <= cmp_idx;
            end
         end
         ST_ACC: begin
            // Load the divider with (2*sum + n) / (2*n)
            num_ff      <= NUM_W'({sum_next, 1'b0}) + NUM_W'(seen_next);
            dsh_ff      <= NUM_W'({seen_next, 1'b0}) << (IDX_W - 1);
            quo_ff      <= '0;
            step_cnt_ff <= '0;
         end
         ST_DIV: begin
            if (quo_bit) num_ff <= num_ff - dsh_ff;
            dsh_ff      <= dsh_ff >> 1;
            quo_ff      <= IDX_W'({quo_ff, quo_bit});
            step_cnt_ff <= step_cnt_ff + STEP_CW'(1);
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_data_ff.direction_index  <= dir_avg;
               rsp_data_ff.direction_tenths <= TENTHS_W'(tenths_full);
            end
         end
         default: begin
            scan_ff <= '0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/wind_vane_direction_estimator.sv @@
// ----------------------------------------------------------------------------
// wind_vane_direction_estimator
// Resistor-ladder wind vane decoder: table loads and ADC samples in, one
// averaged direction per window out.
//
//   Channel  Ports                          Beat
//   request  req_valid/req_ready/req_data   table write or ADC sample
//   response rsp_valid/rsp_ready/rsp_data   averaged index and angle
//   csr      csr_wr_en/csr_index/csr_wdata  register write, no wait
//
// A table write is stored by the back end straight from idle. A sample runs
// the table scan of one entry per cycle through the single memory read port
// and multiplier. A sample that closes a window then goes on through the
// divider and output load. The two-entry queue keeps taking requests, while it
// has room, as the back end works or the response waits. Reset clears control
// state and sets registers to defaults; the table is undefined until written.
// ----------------------------------------------------------------------------
module wind_vane_direction_estimator #(
   parameter int NUM_DIRECTIONS = 16,
   parameter int ADC_FULL_SCALE = 4095,
   parameter int MAX_SAMPLES    = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  wvde_pkg::wvde_req_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output wvde_pkg::wvde_rsp_type                 rsp_data,
   input  logic                                   csr_wr_en,
   input  logic [wvde_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wvde_pkg::CSR_DAT_W-1:0]         csr_wdata
);
   import wvde_pkg::*;

   localparam logic [31:0] MAX_V = 32'(MAX_SAMPLES);

   logic [RES_W-1:0]  series_ff, series_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [STEP_W-1:0] step_ff,   step_in;
   logic [CNT_W-1:0]  window_limit;
   wvde_cfg_type      cfg;

   logic              push_valid, push_ready;
   wvde_item_type     push_item;
   logic              pop_valid, pop_ready;
   wvde_item_type     pop_item;

   // Register writes
   always_comb begin
      series_in = series_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SERIES_RES: series_in = csr_wdata[RES_W-1:0];
            CSR_SAMPLE_CNT: count_in  = csr_wdata[CNT_W-1:0];
            CSR_DIR_STEP:   step_in   = csr_wdata[STEP_W-1:0];
            default:        series_in = series_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff <= RES_W'(10000);
         count_ff  <= CNT_W'(64);
         step_ff   <= STEP_W'(225);
      end else begin
         series_ff <= series_in;
         count_ff  <= count_in;
         step_ff   <= step_in;
      end
   end

   // Clamp window length to 1..MAX_SAMPLES
   always_comb begin
      priority if (count_ff == '0) begin
         window_limit = CNT_W'(1);
      end else if (int'(count_ff) > MAX_SAMPLES) begin
         window_limit = MAX_V[CNT_W-1:0];
      end else begin
         window_limit = count_ff;
      end
   end

   assign cfg.series_resistance = series_ff;
   assign cfg.window_limit      = window_limit;
   assign cfg.direction_step    = step_ff;

   wvde_front #(
      .NUM_DIRECTIONS (NUM_DIRECTIONS),
      .ADC_FULL_SCALE (ADC_FULL_SCALE)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   wvde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   wvde_back #(
      .NUM_DIRECTIONS (NUM_DIRECTIONS),
      .ADC_FULL_SCALE (ADC_FULL_SCALE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_item),
      .cfg        (cfg),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ hdl/wvde_checker.sv @@
// ----------------------------------------------------------------------------
// wvde_checker
// Port-level checks of the wind vane direction estimator, bound to the top.
// ----------------------------------------------------------------------------
module wvde_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input wvde_pkg::wvde_rsp_type rsp_data
);
   import wvde_pkg::*;

   // Reset empties the output register
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // Index zero always maps to angle zero
   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.direction_index == '0) |-> (rsp_data.direction_tenths == '0))
      else $error("nonzero angle for index zero");

endmodule

bind wind_vane_direction_estimator wvde_checker u_wvde_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
